// File: src/tca_pkg.sv
package tca_pkg;

  // Width of one limb of the pipelined multipliers.
  localparam int LIMB_W = 32;

  // Pi in unsigned fixed point with 62 fraction bits.
  localparam int PI_W = 64;
  localparam logic [PI_W-1:0] PI_Q62 = 64'hC90F_DAA2_2168_C235;

  // Width of the area result; the divider's quotient has this width too.
  localparam int Q_W = 64;

  // Status that leaves the divider next to the quotient.
  typedef struct packed {
    logic vld;
    logic nondeg;
    logic sat;
  } tca_flags_t;

endpackage

// File: src/tca_front.sv
module tca_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  logic signed [COORD_BITS-1:0] ax_i,
  input  logic signed [COORD_BITS-1:0] ay_i,
  input  logic signed [COORD_BITS-1:0] bx_i,
  input  logic signed [COORD_BITS-1:0] by_i,
  input  logic signed [COORD_BITS-1:0] cx_i,
  input  logic signed [COORD_BITS-1:0] cy_i,
  output logic                      vld_o,
  output logic                      nondeg_o,
  output logic [2*COORD_BITS:0]     kabs_o,
  output logic [2*COORD_BITS:0]     sa_o,
  output logic [2*COORD_BITS:0]     sb_o,
  output logic [2*COORD_BITS:0]     sc_o
);

  localparam int C  = COORD_BITS;
  localparam int DFW = C + 1;
  localparam int PRW = 2 * C + 2;
  localparam int SW  = 2 * C + 1;

  logic [3:0] vld_q;

  // Differences: b-a (x,y), c-a (x,y), c-b (x,y).
  logic signed [DFW-1:0] dif_d [6];
  logic signed [DFW-1:0] dif_q [6];
  logic signed [PRW-1:0] p1_d, p2_d, p1_q, p2_q;
  logic signed [PRW-1:0] sqf [6];
  logic [2*C-1:0]        sq_q [6];
  logic signed [PRW-1:0] k_d, k_q;
  logic [SW-1:0]         sa_d, sb_d, sc_d, sa_q, sb_q, sc_q;
  logic [SW-1:0]         sa2_q, sb2_q, sc2_q, kabs_q;
  logic                  nz_q;

  always_comb begin
    dif_d[0] = DFW'(bx_i) - DFW'(ax_i);
    dif_d[1] = DFW'(by_i) - DFW'(ay_i);
    dif_d[2] = DFW'(cx_i) - DFW'(ax_i);
    dif_d[3] = DFW'(cy_i) - DFW'(ay_i);
    dif_d[4] = DFW'(cx_i) - DFW'(bx_i);
    dif_d[5] = DFW'(cy_i) - DFW'(by_i);
  end

  always_comb begin
    p1_d = PRW'(dif_q[0]) * PRW'(dif_q[3]);
    p2_d = PRW'(dif_q[1]) * PRW'(dif_q[2]);
    for (int i = 0; i < 6; i++) begin
      sqf[i] = PRW'(dif_q[i]) * PRW'(dif_q[i]);
    end
  end

  always_comb begin
    k_d  = p1_q - p2_q;
    sa_d = SW'(sq_q[0]) + SW'(sq_q[1]);
    sb_d = SW'(sq_q[2]) + SW'(sq_q[3]);
    sc_d = SW'(sq_q[4]) + SW'(sq_q[5]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 6; i++) begin
        dif_q[i] <= dif_d[i];
        sq_q[i]  <= sqf[i][2*C-1:0];
      end
      p1_q   <= p1_d;
      p2_q   <= p2_d;
      k_q    <= k_d;
      sa_q   <= sa_d;
      sb_q   <= sb_d;
      sc_q   <= sc_d;
      kabs_q <= k_q[PRW-1] ? SW'(-k_q) : SW'(k_q);
      nz_q   <= (k_q != '0);
      sa2_q  <= sa_q;
      sb2_q  <= sb_q;
      sc2_q  <= sc_q;
    end
  end

  assign vld_o    = vld_q[3];
  assign nondeg_o = nz_q;
  assign kabs_o   = kabs_q;
  assign sa_o     = sa2_q;
  assign sb_o     = sb2_q;
  assign sc_o     = sc2_q;

endmodule

// File: src/tca_mul.sv
module tca_mul #(
  parameter int AW  = 26,
  parameter int BW  = 26,
  parameter int PLW = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  logic [AW-1:0]  a_i,
  input  logic [BW-1:0]  b_i,
  input  logic [PLW-1:0] pl_i,
  output logic           vld_o,
  output logic [AW+BW-1:0] p_o,
  output logic [PLW-1:0] pl_o
);

  // One limb-by-limb partial product is added per stage.
  localparam int LW  = tca_pkg::LIMB_W;
  localparam int NA  = (AW + LW - 1) / LW;
  localparam int NB  = (BW + LW - 1) / LW;
  localparam int NS  = NA * NB;
  localparam int PW  = AW + BW;
  localparam int APW = NA * LW;
  localparam int BPW = NB * LW;

  logic           vld_q  [NS];
  logic [APW-1:0] a_q    [NS];
  logic [BPW-1:0] b_q    [NS];
  logic [PW-1:0]  acc_q  [NS];
  logic [PLW-1:0] pl_q   [NS];

  logic [APW-1:0]      a_in   [NS];
  logic [BPW-1:0]      b_in   [NS];
  logic [PW-1:0]       acc_in [NS];
  logic [PLW-1:0]      pl_in  [NS];
  logic [2*LW-1:0]     pp     [NS];
  logic [PW+2*LW-1:0]  sh     [NS];
  logic [PW-1:0]       acc_d  [NS];

  always_comb begin
    a_in[0]   = APW'(a_i);
    b_in[0]   = BPW'(b_i);
    acc_in[0] = '0;
    pl_in[0]  = pl_i;
    for (int k = 1; k < NS; k++) begin
      a_in[k]   = a_q[k-1];
      b_in[k]   = b_q[k-1];
      acc_in[k] = acc_q[k-1];
      pl_in[k]  = pl_q[k-1];
    end
    for (int k = 0; k < NS; k++) begin
      pp[k]    = (2*LW)'(a_in[k][LW*(k/NB) +: LW]) * (2*LW)'(b_in[k][LW*(k%NB) +: LW]);
      sh[k]    = {PW'(0), pp[k]} << (LW * ((k / NB) + (k % NB)));
      acc_d[k] = acc_in[k] + sh[k][PW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int k = 1; k < NS; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NS; k++) begin
        a_q[k]   <= a_in[k];
        b_q[k]   <= b_in[k];
        acc_q[k] <= acc_d[k];
        pl_q[k]  <= pl_in[k];
      end
    end
  end

  assign vld_o = vld_q[NS-1];
  assign p_o   = acc_q[NS-1];
  assign pl_o  = pl_q[NS-1];

endmodule

// File: src/tca_div.sv
module tca_div #(
  parameter int MW = 91,
  parameter int DW = 50
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     vld_i,
  input  logic                     nondeg_i,
  input  logic [MW-1:0]            m_i,
  input  logic [DW-1:0]            d_i,
  output tca_pkg::tca_flags_t      flags_o,
  output logic [tca_pkg::Q_W-1:0]  q_o
);

  // Stage zero checks for overflow, then one quotient bit per stage.
  localparam int QW  = tca_pkg::Q_W;
  localparam int NST = QW + 1;
  localparam int HW  = MW - QW;
  localparam int CW  = (HW > DW) ? HW : DW;

  logic          vld_q [NST];
  logic          nd_q  [NST];
  logic          sat_q [NST];
  logic [DW-1:0] rem_q [NST];
  logic [DW-1:0] d_q   [NST];
  logic [QW-1:0] lo_q  [NST];
  logic [QW-1:0] quo_q [NST];

  logic [HW-1:0] hi;
  logic          sat0;
  logic [DW:0]   r2    [NST];
  logic          ge    [NST];
  logic [DW-1:0] rem_d [NST];

  always_comb begin
    hi   = m_i[MW-1:QW];
    sat0 = (CW'(hi) >= CW'(d_i));
    r2[0]    = '0;
    ge[0]    = 1'b0;
    rem_d[0] = DW'(hi);
    for (int k = 1; k < NST; k++) begin
      r2[k]    = {rem_q[k-1], lo_q[k-1][QW-1]};
      ge[k]    = (r2[k] >= {1'b0, d_q[k-1]});
      rem_d[k] = ge[k] ? DW'(r2[k] - {1'b0, d_q[k-1]}) : DW'(r2[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int k = 1; k < NST; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nd_q[0]  <= nondeg_i;
      sat_q[0] <= sat0;
      rem_q[0] <= rem_d[0];
      d_q[0]   <= d_i;
      lo_q[0]  <= m_i[QW-1:0];
      quo_q[0] <= '0;
      for (int k = 1; k < NST; k++) begin
        nd_q[k]  <= nd_q[k-1];
        sat_q[k] <= sat_q[k-1];
        rem_q[k] <= rem_d[k];
        d_q[k]   <= d_q[k-1];
        lo_q[k]  <= {lo_q[k-1][QW-2:0], 1'b0};
        quo_q[k] <= {quo_q[k-1][QW-2:0], ge[k]};
      end
    end
  end

  assign flags_o.vld    = vld_q[NST-1];
  assign flags_o.nondeg = nd_q[NST-1];
  assign flags_o.sat    = sat_q[NST-1];
  assign q_o            = quo_q[NST-1];

endmodule

// File: src/triangle_circumcircle_area.sv
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata: six signed coordinates
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: area, tuser: status flags
//
// One triangle enters per cycle unless the output stalls; the block is a single
// stall-all pipeline. At the default parameters it has 4 front stages, 10 multiplier
// stages (one 32x32 limb product each), 65 divider stages (an overflow check, then one
// quotient bit each) and the output register. Reset clears only the valid bits of
// every stage. While a result waits at the output, the whole pipeline holds and
// s_axis_tready drops; nothing is lost or repeated.
module triangle_circumcircle_area #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // From bit 0 up: first_x, first_y, second_x, second_y, third_x, third_y.
  input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // circle_area.
  output logic [tca_pkg::Q_W-1:0] m_axis_tdata,
  // From bit 0 up: valid_res, saturated.
  output logic [1:0] m_axis_tuser
);

  localparam int C     = COORD_BITS;
  localparam int SW    = 2 * C + 1;          // squared side length
  localparam int KW    = 2 * C + 1;          // magnitude of the cross product
  localparam int DW    = 2 * KW;             // squared cross product
  localparam int ABW   = 2 * SW;
  localparam int ABCW  = 3 * SW;
  localparam int PW    = ABCW + tca_pkg::PI_W;
  localparam int MWR   = ABCW + FRAC_BITS;
  localparam int MW    = (MWR > tca_pkg::Q_W) ? MWR : tca_pkg::Q_W + 1;
  localparam int SHR   = tca_pkg::Q_W - FRAC_BITS;

  // All stages move together; the output register is the only place a result waits.
  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  logic signed [C-1:0] ax, ay, bx, by, cx, cy;
  assign ax = s_axis_tdata[0*C +: C];
  assign ay = s_axis_tdata[1*C +: C];
  assign bx = s_axis_tdata[2*C +: C];
  assign by = s_axis_tdata[3*C +: C];
  assign cx = s_axis_tdata[4*C +: C];
  assign cy = s_axis_tdata[5*C +: C];

  // Front: differences, products, cross product and the three squared sides.
  logic          f_vld, f_nd;
  logic [KW-1:0] f_kabs;
  logic [SW-1:0] f_sa, f_sb, f_sc;

  tca_front #(.COORD_BITS(C)) u_front (
    .clk_i, .rst_ni, .en_i(adv), .vld_i(s_axis_tvalid && s_axis_tready),
    .ax_i(ax), .ay_i(ay), .bx_i(bx), .by_i(by), .cx_i(cx), .cy_i(cy),
    .vld_o(f_vld), .nondeg_o(f_nd), .kabs_o(f_kabs),
    .sa_o(f_sa), .sb_o(f_sb), .sc_o(f_sc)
  );

  // A*B, carrying |K|, C and the triangle flag.
  localparam int PL1 = KW + SW + 1;
  logic           m1_vld;
  logic [ABW-1:0] m1_p;
  logic [PL1-1:0] m1_pl;

  tca_mul #(.AW(SW), .BW(SW), .PLW(PL1)) u_mul_ab (
    .clk_i, .rst_ni, .en_i(adv), .vld_i(f_vld), .a_i(f_sa), .b_i(f_sb),
    .pl_i({f_kabs, f_sc, f_nd}), .vld_o(m1_vld), .p_o(m1_p), .pl_o(m1_pl)
  );

  // K squared, carrying A*B, C and the flag.
  localparam int PL2 = ABW + SW + 1;
  logic           m2_vld;
  logic [DW-1:0]  m2_p;
  logic [PL2-1:0] m2_pl;

  tca_mul #(.AW(KW), .BW(KW), .PLW(PL2)) u_mul_kk (
    .clk_i, .rst_ni, .en_i(adv), .vld_i(m1_vld),
    .a_i(m1_pl[PL1-1 -: KW]), .b_i(m1_pl[PL1-1 -: KW]),
    .pl_i({m1_p, m1_pl[SW:0]}), .vld_o(m2_vld), .p_o(m2_p), .pl_o(m2_pl)
  );

  // A*B*C, carrying K squared and the flag.
  localparam int PL3 = DW + 1;
  logic            m3_vld;
  logic [ABCW-1:0] m3_p;
  logic [PL3-1:0]  m3_pl;

  tca_mul #(.AW(ABW), .BW(SW), .PLW(PL3)) u_mul_abc (
    .clk_i, .rst_ni, .en_i(adv), .vld_i(m2_vld),
    .a_i(m2_pl[PL2-1 -: ABW]), .b_i(m2_pl[SW:1]),
    .pl_i({m2_p, m2_pl[0]}), .vld_o(m3_vld), .p_o(m3_p), .pl_o(m3_pl)
  );

  // Scale by pi in Q62.
  logic           m4_vld;
  logic [PW-1:0]  m4_p;
  logic [PL3-1:0] m4_pl;

  tca_mul #(.AW(ABCW), .BW(tca_pkg::PI_W), .PLW(PL3)) u_mul_pi (
    .clk_i, .rst_ni, .en_i(adv), .vld_i(m3_vld), .a_i(m3_p), .b_i(tca_pkg::PI_Q62),
    .pl_i(m3_pl), .vld_o(m4_vld), .p_o(m4_p), .pl_o(m4_pl)
  );

  // The fraction shift and the 2^64 from pi's scale and the factor four fold into
  // one right shift of the numerator; the divider then sees floor(m4_p / 2^SHR).
  logic [MW-1:0] num;
  assign num = MW'(m4_p >> SHR);

  tca_pkg::tca_flags_t       dv_flags;
  logic [tca_pkg::Q_W-1:0]   dv_q;

  tca_div #(.MW(MW), .DW(DW)) u_div (
    .clk_i, .rst_ni, .en_i(adv), .vld_i(m4_vld), .nondeg_i(m4_pl[0]),
    .m_i(num), .d_i(m4_pl[PL3-1:1]), .flags_o(dv_flags), .q_o(dv_q)
  );

  // Output register: degenerate triangles report zero, overflow clamps to all ones.
  logic                    out_vld_q;
  logic [tca_pkg::Q_W-1:0] area_d, area_q;
  logic                    nd_q, sat_d, sat_q;

  always_comb begin
    if (!dv_flags.nondeg) begin
      area_d = '0;
      sat_d  = 1'b0;
    end else if (dv_flags.sat) begin
      area_d = '1;
      sat_d  = 1'b1;
    end else begin
      area_d = dv_q;
      sat_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= dv_flags.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      area_q <= area_d;
      nd_q   <= dv_flags.nondeg;
      sat_q  <= sat_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = area_q;
  assign m_axis_tuser  = {sat_q, nd_q};

endmodule

// File: src/tca_checker.sv
module tca_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // A degenerate triangle reports zero area and no overflow.
  a_degenerate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
    else $error("degenerate triangle with nonzero result");

  // Overflow only on a valid triangle and always clamps to all ones.
  a_sat_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> (&m_axis_tdata) && m_axis_tuser[0])
    else $error("saturated result not clamped");

  // With no result pending the block takes input.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

endmodule

bind triangle_circumcircle_area tca_checker u_tca_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);
